// ===== sv/sdc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sliding door controller: widths, fixed-point constants,
// mode/event/action codes and the door state struct. No dependencies.
package sdc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PROG_W    = FRAC_BITS + 1;
  localparam int STEP_W    = 17;
  localparam int ACT_W     = 3;
  localparam int MODE_W    = 2;
  localparam int EV_W      = 3;
  localparam int SUM_W     = ((PROG_W > STEP_W) ? PROG_W : STEP_W) + 1;

  localparam logic [PROG_W-1:0] ONE_FP = PROG_W'(1) << FRAC_BITS;

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STAY_OPEN  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SENSOR_ENA = 1'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLOSED  = 2'd0,
    MODE_OPENING = 2'd1,
    MODE_OPEN    = 2'd2,
    MODE_CLOSING = 2'd3
  } mode_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE    = 3'd0,
    EV_CLOSING = 3'd1,
    EV_OPENING = 3'd2,
    EV_CLOSED  = 3'd3,
    EV_OPEN    = 3'd4
  } event_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK   = 3'd0,
    ACT_OPEN   = 3'd1,
    ACT_CLOSE  = 3'd2,
    ACT_ARRIVE = 3'd3,
    ACT_STAY   = 3'd4,
    ACT_LEAVE  = 3'd5
  } action_t;

  typedef struct packed {
    mode_t             mode;
    logic [PROG_W-1:0] progress;
    logic              close_pending;
  } door_st_t;

endpackage

// ===== sv/sdc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the door controller input and result beats.
// Depends on sdc_pkg for field widths.
interface sdc_in_if import sdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [STEP_W-1:0] step;
  logic              sensor_hit;

  modport source (output valid, action, step, sensor_hit, input ready);
  modport sink   (input valid, action, step, sensor_hit, output ready);
endinterface

interface sdc_out_if import sdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] door_state;
  logic [EV_W-1:0]   event_res;

  modport source (output valid, door_state, event_res, input ready);
  modport sink   (input valid, door_state, event_res, output ready);
endinterface

// ===== sv/sdc_next.sv =====
`timescale 1ns / 1ps
// Next-state logic of the door: one input beat applied to the current state.
// Depends on sdc_pkg.
module sdc_next import sdc_pkg::*; (
  input  door_st_t          cur,
  input  action_t           action,
  input  logic [STEP_W-1:0] step,
  input  logic              sensed,
  input  logic              stay_open,
  output door_st_t          nxt,
  output event_t            ev
);

  logic              full;
  logic [PROG_W-1:0] inv_prog;
  logic [PROG_W-1:0] tick_base;
  logic [SUM_W-1:0]  tick_sum;

  assign full     = (cur.progress >= ONE_FP);
  assign inv_prog = ONE_FP - cur.progress;

  always_comb begin
    nxt       = cur;
    ev        = EV_NONE;
    tick_base = cur.progress;
    tick_sum  = '0;
    case (action)
      ACT_TICK: begin
        case (cur.mode)
          MODE_OPENING: begin
            if (full) begin
              nxt.mode  = MODE_OPEN;
              tick_base = '0;
              ev        = EV_OPEN;
            end
          end
          MODE_OPEN: begin
            if (full && cur.close_pending) begin
              nxt.mode          = MODE_CLOSING;
              nxt.close_pending = 1'b0;
              tick_base         = '0;
              ev                = EV_CLOSING;
            end
          end
          MODE_CLOSING: begin
            if (full) begin
              nxt.mode          = MODE_CLOSED;
              nxt.close_pending = 1'b0;
              tick_base         = '0;
              ev                = EV_CLOSED;
            end
          end
          default: ;
        endcase
        // saturate at full travel
        tick_sum = SUM_W'(tick_base) + SUM_W'(step);
        nxt.progress = (tick_sum > SUM_W'(ONE_FP)) ? ONE_FP : tick_sum[PROG_W-1:0];
      end
      ACT_OPEN, ACT_ARRIVE: begin
        if (action == ACT_OPEN || sensed) begin
          if (action == ACT_ARRIVE) nxt.close_pending = 1'b0;
          if (cur.mode == MODE_CLOSED) begin
            nxt.mode     = MODE_OPENING;
            nxt.progress = '0;
            ev           = EV_OPENING;
          end else if (cur.mode == MODE_CLOSING) begin
            nxt.mode     = MODE_OPENING;
            nxt.progress = inv_prog;
            ev           = EV_OPENING;
          end
        end
      end
      ACT_CLOSE: begin
        if (cur.mode == MODE_OPEN) begin
          nxt.mode     = MODE_CLOSING;
          nxt.progress = '0;
          ev           = EV_CLOSING;
        end else if (cur.mode == MODE_OPENING) begin
          nxt.mode     = MODE_CLOSING;
          nxt.progress = inv_prog;
          ev           = EV_CLOSING;
        end
      end
      ACT_STAY: begin
        if (sensed && cur.mode == MODE_OPENING && full) begin
          nxt.mode     = MODE_OPEN;
          nxt.progress = '0;
          ev           = EV_OPEN;
        end
      end
      ACT_LEAVE: begin
        if (sensed) begin
          if (cur.mode == MODE_OPEN) begin
            if (!stay_open && full) begin
              nxt.mode     = MODE_CLOSING;
              nxt.progress = '0;
              ev           = EV_CLOSING;
            end else begin
              nxt.close_pending = !stay_open;
            end
          end else if (cur.mode == MODE_OPENING) begin
            nxt.close_pending = !stay_open;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/sliding_door_controller.sv =====
`timescale 1ns / 1ps
// Sliding door controller top level. An input beat passes the input register, then
// the state update into the result register, before its result beat is offered.
// Throughput: one beat per cycle while out_ch.ready does not hold the result stage; the state update closes the loop.
// Reset (rst_n low, synchronous): door closed, progress 0, no pending close,
// stay_open 0, sensor_enabled 1, both pipeline stages empty.
module sliding_door_controller import sdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sdc_in_if.sink                in_ch,
  sdc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic              stay_open_r;
  logic              sensor_ena_r;

  logic              s1_vld_r;
  action_t           s1_action_r;
  logic [STEP_W-1:0] s1_step_r;
  logic              s1_hit_r;

  door_st_t          st_r;
  door_st_t          st_nxt;
  event_t            ev_nxt;

  logic              out_vld_r;
  mode_t             out_mode_r;
  event_t            out_ev_r;

  logic              adv2;
  logic              adv1;
  logic              upd;

  assign adv2 = !out_vld_r || out_ch.ready;
  assign adv1 = !s1_vld_r || adv2;
  assign upd  = s1_vld_r && adv2;

  assign in_ch.ready       = adv1;
  assign out_ch.valid      = out_vld_r;
  assign out_ch.door_state = out_mode_r;
  assign out_ch.event_res  = out_ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stay_open_r  <= 1'b0;
      sensor_ena_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_STAY_OPEN:  stay_open_r  <= cfg_wdata[0];
        CFG_SENSOR_ENA: sensor_ena_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv1) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_ch.valid) begin
      s1_action_r <= action_t'(in_ch.action);
      s1_step_r   <= in_ch.step;
      s1_hit_r    <= in_ch.sensor_hit;
    end
  end

  sdc_next u_next (
    .cur       (st_r),
    .action    (s1_action_r),
    .step      (s1_step_r),
    .sensed    (s1_hit_r && sensor_ena_r),
    .stay_open (stay_open_r),
    .nxt       (st_nxt),
    .ev        (ev_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '{mode: MODE_CLOSED, progress: '0, close_pending: 1'b0};
      out_vld_r <= 1'b0;
    end else if (adv2) begin
      out_vld_r <= s1_vld_r;
      if (s1_vld_r) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_mode_r <= st_nxt.mode;
      out_ev_r   <= ev_nxt;
    end
  end

  // progress never passes full travel
  a_prog_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.progress <= ONE_FP)
    else $error("door progress above full travel");

  // a mode change always reports an event
  a_change_ev: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && st_nxt.mode != st_r.mode) |=> (out_ev_r != EV_NONE))
    else $error("mode change without event");

  // a fully open event leaves the door open, fully closed leaves it closed
  a_ev_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ev_r == EV_OPEN) |-> (out_mode_r == MODE_OPEN))
    else $error("fully open event with wrong door state");

  a_ev_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ev_r == EV_CLOSED) |-> (out_mode_r == MODE_CLOSED))
    else $error("fully closed event with wrong door state");

endmodule
